@@ rtl/tnp_pkg.sv @@
// Shared constants, types and command/status bundles of the telnet receive parser.
`default_nettype none

package tnp_pkg;

  // Line store sizing. The usable depth is capped so that a line run never
  // exceeds the largest number of results that one byte may cause.
  localparam int LINE_DEPTH   = 32;
  localparam int MAX_RESULTS  = 32;
  localparam int USABLE_DEPTH = (LINE_DEPTH < MAX_RESULTS) ? LINE_DEPTH : MAX_RESULTS;
  localparam int FILL_W       = $clog2(USABLE_DEPTH + 1);
  localparam int IDX_W        = $clog2(USABLE_DEPTH);

  // Telnet protocol bytes.
  localparam logic [7:0] B_IAC    = 8'd255;
  localparam logic [7:0] B_SB     = 8'd250;
  localparam logic [7:0] B_WILL   = 8'd251;
  localparam logic [7:0] B_WONT   = 8'd252;
  localparam logic [7:0] B_DO     = 8'd253;
  localparam logic [7:0] B_DONT   = 8'd254;
  localparam logic [7:0] B_CR     = 8'd13;
  localparam logic [7:0] B_LF     = 8'd10;
  localparam logic [7:0] B_NUL    = 8'd0;
  localparam logic [7:0] OPT_ECHO = 8'd1;

  // Result kinds.
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       store;        // append the accepted byte to the line store
    logic       reply_start;  // latch option byte and reply command, restart reply count
    logic [7:0] reply_code;   // command byte of the reply
    logic       line_start;   // restart the line drain
    logic       emit_reply;   // load the next reply byte into the output register
    logic       emit_line;    // load the next line byte or the empty marker
  } tnp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_iac;
    logic is_sb;
    logic is_will;
    logic is_wont;
    logic is_do;
    logic is_dont;
    logic is_cr;
    logic is_lf;
    logic is_nul;
    logic is_echo;
    logic out_free;     // output register can take a result this cycle
    logic reply_last;   // the reply byte on offer is the third one
    logic line_last;    // the line result on offer is the final one
  } tnp_stat_t;

endpackage

`default_nettype wire

@@ rtl/tnp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tnp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/tnp_ctrl.sv @@
// Controller: telnet parse state machine and the result sequencer.
`default_nettype none

module tnp_ctrl
  import tnp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      rx_valid_i,
  output logic           rx_ready_o,
  input  wire tnp_stat_t stat_i,
  output tnp_cmd_t       cmd_o
);

  // Parse states.
  localparam logic [3:0] ST_DATA = 4'd0;
  localparam logic [3:0] ST_IAC  = 4'd1;
  localparam logic [3:0] ST_CR   = 4'd2;
  localparam logic [3:0] ST_SB   = 4'd3;
  localparam logic [3:0] ST_SE   = 4'd4;
  localparam logic [3:0] ST_WILL = 4'd5;
  localparam logic [3:0] ST_WONT = 4'd6;
  localparam logic [3:0] ST_DO   = 4'd7;
  localparam logic [3:0] ST_DONT = 4'd8;

  // Sequencer states.
  localparam logic [1:0] SEQ_IDLE  = 2'd0;
  localparam logic [1:0] SEQ_REPLY = 2'd1;
  localparam logic [1:0] SEQ_LINE  = 2'd2;

  logic [3:0] parse_q, parse_d;
  logic [1:0] seq_q, seq_d;
  logic       accept;
  logic       as_data;

  assign rx_ready_o = (seq_q == SEQ_IDLE);
  assign accept     = rx_valid_i && rx_ready_o;

  // Next-state and command decode.
  always_comb begin
    parse_d = parse_q;
    seq_d   = seq_q;
    as_data = 1'b0;
    cmd_o   = '0;
    cmd_o.emit_reply = (seq_q == SEQ_REPLY) && stat_i.out_free;
    cmd_o.emit_line  = (seq_q == SEQ_LINE) && stat_i.out_free;

    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          unique case (parse_q)
            ST_IAC: begin
              priority if (stat_i.is_sb) begin
                parse_d = ST_SB;
              end else if (stat_i.is_will) begin
                parse_d = ST_WILL;
              end else if (stat_i.is_wont) begin
                parse_d = ST_WONT;
              end else if (stat_i.is_do) begin
                parse_d = ST_DO;
              end else if (stat_i.is_dont) begin
                parse_d = ST_DONT;
              end else begin
                // An escaped IAC stores one 255 byte; other commands are ignored.
                cmd_o.store = stat_i.is_iac;
                parse_d     = ST_DATA;
              end
            end
            ST_SB: begin
              if (stat_i.is_iac) begin
                parse_d = ST_SE;
              end
            end
            ST_SE: begin
              parse_d = ST_DATA;
            end
            ST_WILL, ST_WONT, ST_DO, ST_DONT: begin
              parse_d           = ST_DATA;
              seq_d             = SEQ_REPLY;
              cmd_o.reply_start = 1'b1;
              if (parse_q == ST_WILL) begin
                cmd_o.reply_code = B_DO;
              end else if (parse_q == ST_WONT) begin
                cmd_o.reply_code = B_DONT;
              end else if (parse_q == ST_DO && stat_i.is_echo) begin
                cmd_o.reply_code = B_WILL;
              end else begin
                cmd_o.reply_code = B_WONT;
              end
            end
            ST_CR: begin
              parse_d = ST_DATA;
              if (stat_i.is_nul || stat_i.is_lf) begin
                seq_d            = SEQ_LINE;
                cmd_o.line_start = 1'b1;
              end else begin
                as_data = 1'b1;
              end
            end
            default: begin
              // Data state, and any code that should never arise.
              parse_d = ST_DATA;
              as_data = 1'b1;
            end
          endcase

          // Ordinary byte handling as in the data state.
          if (as_data) begin
            priority if (stat_i.is_iac) begin
              parse_d = ST_IAC;
            end else if (stat_i.is_cr) begin
              parse_d = ST_CR;
            end else begin
              cmd_o.store = 1'b1;
            end
          end
        end
      end
      SEQ_REPLY: begin
        if (cmd_o.emit_reply && stat_i.reply_last) begin
          seq_d = SEQ_IDLE;
        end
      end
      SEQ_LINE: begin
        if (cmd_o.emit_line && stat_i.line_last) begin
          seq_d = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q <= ST_DATA;
      seq_q   <= SEQ_IDLE;
    end else begin
      parse_q <= parse_d;
      seq_q   <= seq_d;
    end
  end

  // A single accepted byte triggers at most one datapath action.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.store, cmd_o.reply_start, cmd_o.line_start}))
    else $error("conflicting datapath actions on one byte");

  // A reply or line run always leaves the parser in the data state, waiting on a data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_IDLE) && (seq_d != SEQ_IDLE) |-> parse_d == ST_DATA)
    else $error("result run started outside the data state");

endmodule

`default_nettype wire

@@ rtl/tnp_dp.sv @@
// Datapath: byte classification, line store, reply and drain counters, output register.
`default_nettype none

module tnp_dp
  import tnp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] rx_byte_i,
  input  wire tnp_cmd_t   cmd_i,
  output tnp_stat_t       stat_o,
  output logic            m_valid_o,
  input  wire logic       m_ready_i,
  output logic [7:0]      m_byte_o,
  output logic [1:0]      m_kind_o,
  output logic            m_ovf_o,
  output logic            m_last_o
);

  logic [FILL_W-1:0] fill_q, fill_d;
  logic              ovf_q, ovf_d;
  logic [1:0]        rep_idx_q, rep_idx_d;
  logic [IDX_W-1:0]  drain_idx_q, drain_idx_d;
  logic [7:0]        rep_cmd_q, rep_opt_q;
  logic [7:0]        rdata;
  logic              has_room;
  logic              ram_we;
  logic              fill_zero;
  logic              load;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [1:0]        out_kind_q, out_kind_d;
  logic              out_ovf_q, out_ovf_d;
  logic              out_last_q, out_last_d;

  // Byte classification for the controller.
  always_comb begin
    stat_o            = '0;
    stat_o.is_iac     = (rx_byte_i == B_IAC);
    stat_o.is_sb      = (rx_byte_i == B_SB);
    stat_o.is_will    = (rx_byte_i == B_WILL);
    stat_o.is_wont    = (rx_byte_i == B_WONT);
    stat_o.is_do      = (rx_byte_i == B_DO);
    stat_o.is_dont    = (rx_byte_i == B_DONT);
    stat_o.is_cr      = (rx_byte_i == B_CR);
    stat_o.is_lf      = (rx_byte_i == B_LF);
    stat_o.is_nul     = (rx_byte_i == B_NUL);
    stat_o.is_echo    = (rx_byte_i == OPT_ECHO);
    stat_o.out_free   = !out_valid_q || m_ready_i;
    stat_o.reply_last = (rep_idx_q == 2'd2);
    stat_o.line_last  = fill_zero ||
                        ((FILL_W'(drain_idx_q) + FILL_W'(1)) == fill_q);
  end

  assign has_room  = (fill_q < FILL_W'(USABLE_DEPTH));
  assign ram_we    = cmd_i.store && has_room;
  assign fill_zero = (fill_q == '0);
  assign load      = cmd_i.emit_reply || cmd_i.emit_line;

  // Line store; the read port always fetches the entry the drain will offer next.
  tnp_ram #(
    .WIDTH(8),
    .DEPTH(USABLE_DEPTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(fill_q[IDX_W-1:0]),
    .wdata_i(rx_byte_i),
    .raddr_i(drain_idx_d),
    .rdata_o(rdata)
  );

  // Fill count, overflow flag and run counters.
  always_comb begin
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    rep_idx_d   = rep_idx_q;
    drain_idx_d = drain_idx_q;
    if (cmd_i.store) begin
      if (has_room) begin
        fill_d = fill_q + FILL_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.reply_start) begin
      rep_idx_d = 2'd0;
    end else if (cmd_i.emit_reply) begin
      rep_idx_d = rep_idx_q + 2'd1;
    end
    if (cmd_i.line_start) begin
      drain_idx_d = '0;
    end else if (cmd_i.emit_line) begin
      drain_idx_d = IDX_W'(FILL_W'(drain_idx_q) + FILL_W'(1));
      // The line is closed once its final result is loaded.
      if (stat_o.line_last) begin
        fill_d = '0;
        ovf_d  = 1'b0;
      end
    end
  end

  // Result selection into the output register.
  always_comb begin
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_ovf_d  = out_ovf_q;
    out_last_d = out_last_q;
    if (cmd_i.emit_reply) begin
      out_kind_d = KIND_REPLY;
      out_ovf_d  = 1'b0;
      out_last_d = stat_o.reply_last;
      unique case (rep_idx_q)
        2'd0:    out_byte_d = B_IAC;
        2'd1:    out_byte_d = rep_cmd_q;
        default: out_byte_d = rep_opt_q;
      endcase
    end else if (cmd_i.emit_line) begin
      out_kind_d = fill_zero ? KIND_EMPTY : KIND_LINE;
      out_byte_d = fill_zero ? 8'd0 : rdata;
      out_ovf_d  = ovf_q;
      out_last_d = stat_o.line_last;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      rep_idx_q   <= 2'd0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      rep_idx_q   <= rep_idx_d;
      drain_idx_q <= drain_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.reply_start) begin
      rep_cmd_q <= cmd_i.reply_code;
      rep_opt_q <= rx_byte_i;
    end
    out_byte_q <= out_byte_d;
    out_kind_q <= out_kind_d;
    out_ovf_q  <= out_ovf_d;
    out_last_q <= out_last_d;
  end

  assign m_valid_o = out_valid_q;
  assign m_byte_o  = out_byte_q;
  assign m_kind_o  = out_kind_q;
  assign m_ovf_o   = out_ovf_q;
  assign m_last_o  = out_last_q;

  // The fill count never passes the usable store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(USABLE_DEPTH))
    else $error("line fill beyond store depth");

  // Bytes are only dropped once the store is full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> fill_q == FILL_W'(USABLE_DEPTH))
    else $error("overflow flagged with room left");

  // Loading the final line result empties the store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_line && stat_o.line_last |=> fill_q == '0 && !ovf_q)
    else $error("line store not cleared after line end");

endmodule

`default_nettype wire

@@ rtl/telnet_receive_parser.sv @@
// Top level of the telnet receive parser: controller and datapath.
`default_nettype none

// Receive-side telnet parser. One byte enters per item on the slave stream.
// Data bytes and escaped IAC IAC are stored in a line buffer of
// tnp_pkg::USABLE_DEPTH bytes; extra bytes are dropped and flagged. CR LF or
// CR NUL ends the line, which is sent out as a run of line bytes or as one
// empty-line marker. IAC WILL/WONT/DO/DONT x produces a three-byte reply.
// Timing: bytes that cause no result flow at one per cycle. A byte that causes
// a reply or a line end holds the input while its results are loaded into the
// output register at one per cycle, longer if the master side stalls; the line
// buffer's single read port sets the drain rate. The output register lets the
// next byte be taken while the last result is still waiting. No clearing pass
// is needed after reset.
module telnet_receive_parser
  import tnp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser,   // [1:0] out_kind, [2] line_overflow
  output logic            m_axis_tlast
);

  tnp_cmd_t   cmd;
  tnp_stat_t  stat;
  logic [1:0] kind;
  logic       ovf;

  tnp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(s_axis_tvalid),
    .rx_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  tnp_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rx_byte_i(s_axis_tdata),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .m_byte_o (m_axis_tdata),
    .m_kind_o (kind),
    .m_ovf_o  (ovf),
    .m_last_o (m_axis_tlast)
  );

  assign m_axis_tuser = {ovf, kind};

endmodule

`default_nettype wire
